/* rtl/lvli_pkg.sv */
// ---------------------------------------------------------------------------
// LDR voltage-to-lux interpolator package
// Shared widths, calibration table and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lvli_pkg;

    // Calibration ROM geometry and fixed-point formats.
    localparam int ROM_ROWS  = 70;
    localparam int IDX_W     = 7;
    localparam int CODE_W    = 14;
    localparam int LUX_W     = 14;
    localparam int FRAC_BITS = 4;
    localparam int QUO_W     = 14;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int REM_W     = 2 * CODE_W + 1;

    localparam logic [LUX_W-1:0] LUX_MAX_Q4 = 14'd16000;

    // Defaults for the top-level parameters.
    localparam int DEF_TABLE_POINTS = 70;
    localparam int DEF_ADC_BITS     = 10;

    // Breakpoint voltages as ADC codes in Q10.4.
    localparam logic [CODE_W-1:0] BP_CODE [ROM_ROWS] = '{
        14'd0,     14'd65,    14'd196,   14'd360,   14'd622,
        14'd1080,  14'd1506,  14'd1866,  14'd2226,  14'd2521,
        14'd2815,  14'd3110,  14'd3372,  14'd3601,  14'd4190,
        14'd4681,  14'd5140,  14'd5565,  14'd5925,  14'd6285,
        14'd6580,  14'd6875,  14'd7169,  14'd7431,  14'd7660,
        14'd7889,  14'd8086,  14'd8315,  14'd8479,  14'd8675,
        14'd9002,  14'd9297,  14'd9592,  14'd9821,  14'd10050,
        14'd10279, 14'd10639, 14'd10999, 14'd11359, 14'd11654,
        14'd11916, 14'd12178, 14'd12571, 14'd12898, 14'd13160,
        14'd13389, 14'd13585, 14'd13749, 14'd13880, 14'd14011,
        14'd14142, 14'd14240, 14'd14338, 14'd14437, 14'd14502,
        14'd14568, 14'd14633, 14'd14698, 14'd14764, 14'd14797,
        14'd14862, 14'd14895, 14'd14960, 14'd14993, 14'd15059,
        14'd15124, 14'd15190, 14'd15222, 14'd15288, 14'd15320
    };

    // Breakpoint illuminance in lux, Q10.4.
    localparam logic [LUX_W-1:0] BP_LUX [ROM_ROWS] = '{
        14'd0,     14'd2,     14'd5,     14'd8,     14'd16,
        14'd32,    14'd48,    14'd64,    14'd80,    14'd96,
        14'd112,   14'd128,   14'd144,   14'd160,   14'd200,
        14'd240,   14'd280,   14'd320,   14'd360,   14'd400,
        14'd440,   14'd480,   14'd520,   14'd560,   14'd600,
        14'd640,   14'd680,   14'd720,   14'd760,   14'd800,
        14'd880,   14'd960,   14'd1040,  14'd1120,  14'd1200,
        14'd1280,  14'd1440,  14'd1600,  14'd1800,  14'd2000,
        14'd2200,  14'd2400,  14'd2800,  14'd3200,  14'd3600,
        14'd4000,  14'd4400,  14'd4800,  14'd5200,  14'd5600,
        14'd6000,  14'd6400,  14'd6800,  14'd7200,  14'd7600,
        14'd8000,  14'd8400,  14'd8800,  14'd9200,  14'd9600,
        14'd10000, 14'd10400, 14'd10800, 14'd11200, 14'd12000,
        14'd12800, 14'd13600, 14'd14400, 14'd15200, 14'd16000
    };

    function automatic logic [CODE_W-1:0] bp_code(input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] val;
        if (idx < IDX_W'(ROM_ROWS))
        begin
            val = BP_CODE[idx];
        end
        else
        begin
            val = '0;
        end
        return val;
    endfunction

    function automatic logic [LUX_W-1:0] bp_lux(input logic [IDX_W-1:0] idx);
        logic [LUX_W-1:0] val;
        if (idx < IDX_W'(ROM_ROWS))
        begin
            val = BP_LUX[idx];
        end
        else
        begin
            val = '0;
        end
        return val;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic search_step;
        logic fetch;
        logic mult;
        logic div_init;
        logic div_step;
        logic sum;
        logic load_out;
    } lvli_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic direct;
        logic div_last;
        logic out_free;
    } lvli_sts_t;

endpackage

/* rtl/ldr_voltage_to_lux_interpolator_core.sv */
// ---------------------------------------------------------------------------
// LDR voltage-to-lux interpolator core
// Converts one light-sensor ADC code to illuminance by piecewise-linear
// interpolation over a fixed calibration table.
// ---------------------------------------------------------------------------
// Each request carries one raw ADC code from the light-dependent-resistor
// divider and produces one illuminance value in lux times 16 (Q10.4), rounded
// to nearest with ties rounded up. The code is scaled by 16 and compared with
// the calibration breakpoints, which are stored as ADC codes in Q10.4. A zero
// code gives 0, a code at or above the last used breakpoint gives that
// breakpoint's lux (16000 for the full table), and a code landing exactly on
// a breakpoint gives that breakpoint's lux. TABLE_POINTS limits how many
// table rows are used (at most 70, at least 2); ADC_BITS sets the width of
// the code port. One request is processed at a time. A request is taken,
// then passes the binary segment search, the segment fetch and the
// multiplier; a direct result then goes straight to the output load, while
// an interpolated one passes divider setup, a bit-serial restoring divider
// with a 14-bit quotient, the sum and then the output load, which waits
// until the output register is free. The result sits in an output register,
// so a new request is taken as soon as the result has been moved there,
// even if it has not yet been taken downstream.
// ---------------------------------------------------------------------------
module ldr_voltage_to_lux_interpolator_core
    import lvli_pkg::*;
#(
    parameter int TABLE_POINTS = DEF_TABLE_POINTS,
    parameter int ADC_BITS     = DEF_ADC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_BITS-1:0] adc_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LUX_W-1:0]    lux_q4
);

    // Controller and datapath talk only through these two bundles.
    lvli_cmd_t cmd;
    lvli_sts_t sts;

    // The controller owns the input handshake and the operation sequence.
    lvli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the sample, the search bounds, the multiplier and
    // divider registers, and the output register with its valid flag.
    lvli_dp #(
        .TABLE_POINTS (TABLE_POINTS),
        .ADC_BITS     (ADC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adc_code  (adc_code),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .lux_q4    (lux_q4)
    );

endmodule

/* rtl/lvli_ctrl.sv */
// ---------------------------------------------------------------------------
// LDR voltage-to-lux interpolator controller
// One-hot state machine sequencing search, fetch, multiply, divide and output.
// ---------------------------------------------------------------------------
module lvli_ctrl
    import lvli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lvli_sts_t sts,
    output lvli_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEARCH = 8'b0000_0010,
        ST_FETCH  = 8'b0000_0100,
        ST_MULT   = 8'b0000_1000,
        ST_DINIT  = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_SUM    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } lvli_state_t;

    lvli_state_t state_reg;
    lvli_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sts.search_done)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                // A zero sample, a saturated sample or an exact breakpoint
                // already has its result, so the divider is skipped.
                cmd.mult   = 1'b1;
                state_next = sts.direct ? ST_FINISH : ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lvli_dp.sv */
// ---------------------------------------------------------------------------
// LDR voltage-to-lux interpolator datapath
// Binary segment search, segment fetch, multiplier, restoring divider and
// output register.
// ---------------------------------------------------------------------------
module lvli_dp
    import lvli_pkg::*;
#(
    parameter int TABLE_POINTS = DEF_TABLE_POINTS,
    parameter int ADC_BITS     = DEF_ADC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ADC_BITS-1:0] adc_code,
    input  lvli_cmd_t           cmd,
    output lvli_sts_t           sts,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [LUX_W-1:0]    lux_q4
);

    localparam int ROWS_USED = (TABLE_POINTS > ROM_ROWS) ? ROM_ROWS :
                               ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ROWS_USED - 1);
    localparam int XW    = ADC_BITS + FRAC_BITS;
    localparam int CMP_W = (XW > CODE_W) ? XW : CODE_W;
    localparam int NUM_W = 2 * CODE_W;

    // Sample and search bounds.
    logic [XW-1:0]    x_reg;
    logic [IDX_W-1:0] lo_reg;
    logic [IDX_W-1:0] hi_reg;

    // Segment operands.
    logic [LUX_W-1:0]  dy_reg;
    logic [CODE_W-1:0] dx_reg;
    logic [CODE_W-1:0] den_reg;
    logic [LUX_W-1:0]  base_reg;
    logic              direct_reg;
    logic [LUX_W-1:0]  res_reg;
    logic [NUM_W-1:0]  num_reg;

    // Divider.
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Output register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [LUX_W-1:0] lux_q4_reg;

    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [CMP_W-1:0]   x_cmp;
    logic               mid_below;
    logic [IDX_W-1:0]   prev;
    logic [CMP_W-1:0]   code_i;
    logic [CMP_W-1:0]   code_p;
    logic [CMP_W-1:0]   code_last;
    logic [CMP_W-1:0]   dx_full;
    logic               is_zero;
    logic               is_top;
    logic               is_hit;
    logic               rem_ge;
    logic [LUX_W:0]     sum_w;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[IDX_W:1];
    assign x_cmp     = CMP_W'(x_reg);
    assign mid_below = CMP_W'(bp_code(mid)) < x_cmp;

    assign prev      = lo_reg - IDX_W'(1);
    assign code_i    = CMP_W'(bp_code(lo_reg));
    assign code_p    = CMP_W'(bp_code(prev));
    assign code_last = CMP_W'(bp_code(LAST_ROW));
    assign dx_full   = x_cmp - code_p;
    assign is_zero   = (x_reg == '0);
    assign is_top    = (x_cmp >= code_last);
    assign is_hit    = (x_cmp == code_i);

    assign rem_ge = (rem_reg >= dsh_reg);
    assign sum_w  = {1'b0, base_reg} + {1'b0, quo_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg  <= {adc_code, FRAC_BITS'(0)};
            lo_reg <= IDX_W'(1);
            hi_reg <= LAST_ROW;
        end
        else if (cmd.search_step)
        begin
            if (mid_below)
            begin
                lo_reg <= mid + IDX_W'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end

        if (cmd.fetch)
        begin
            dy_reg     <= bp_lux(lo_reg) - bp_lux(prev);
            dx_reg     <= dx_full[CODE_W-1:0];
            den_reg    <= code_i[CODE_W-1:0] - code_p[CODE_W-1:0];
            base_reg   <= bp_lux(prev);
            direct_reg <= is_zero | is_top | is_hit;
            if (is_zero)
            begin
                res_reg <= '0;
            end
            else if (is_top)
            begin
                res_reg <= bp_lux(LAST_ROW);
            end
            else
            begin
                res_reg <= bp_lux(lo_reg);
            end
        end
        else if (cmd.sum)
        begin
            // Round-half-up quotient added to the segment base, then clamped.
            res_reg <= (sum_w > {1'b0, LUX_MAX_Q4}) ? LUX_MAX_Q4 : sum_w[LUX_W-1:0];
        end

        if (cmd.mult)
        begin
            num_reg <= NUM_W'(dy_reg) * NUM_W'(dx_reg);
        end

        if (cmd.div_init)
        begin
            rem_reg <= {num_reg, 1'b0} + REM_W'(den_reg);
            dsh_reg <= REM_W'({den_reg, 1'b0}) << (QUO_W - 1);
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (cmd.load_out)
        begin
            lux_q4_reg <= res_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.search_done = (lo_reg == hi_reg);
    assign sts.direct      = direct_reg;
    assign sts.div_last    = (cnt_reg == CNT_W'(QUO_W - 1));
    assign sts.out_free    = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign lux_q4    = lux_q4_reg;

endmodule
